// ===== hw/rtl/plss_pkg.sv =====
`default_nettype none

package plss_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int ENTRY_WIDTH_DEF = 32;

    localparam int OP_WIDTH    = 3;
    localparam int POS_WIDTH   = 5;
    localparam int VALUE_WIDTH = 32;
    localparam int COUNT_WIDTH = 5;

    localparam logic [OP_WIDTH-1:0] OP_INSERT   = 3'd0;
    localparam logic [OP_WIDTH-1:0] OP_REMOVE   = 3'd1;
    localparam logic [OP_WIDTH-1:0] OP_RETRIEVE = 3'd2;
    localparam logic [OP_WIDTH-1:0] OP_REPLACE  = 3'd3;
    localparam logic [OP_WIDTH-1:0] OP_CLEAR    = 3'd4;

    typedef struct packed {
        logic [OP_WIDTH-1:0]    operation;
        logic [POS_WIDTH-1:0]   position;
        logic [VALUE_WIDTH-1:0] value;
    } req_t;

    typedef struct packed {
        logic                   status;
        logic [VALUE_WIDTH-1:0] entry_out;
        logic [COUNT_WIDTH-1:0] entry_count;
        logic                   is_full;
        logic                   is_empty;
    } rsp_t;

    // broadcast along the cell row, already qualified by bounds and accept
    typedef struct packed {
        logic                 ins;
        logic                 rem;
        logic                 rep;
        logic [POS_WIDTH-1:0] pos;
    } cell_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/plss_req_if.sv =====
`default_nettype none

interface plss_req_if;
    logic           valid;
    logic           ready;
    plss_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/plss_rsp_if.sv =====
`default_nettype none

interface plss_rsp_if;
    logic           valid;
    logic           ready;
    plss_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/positional_list_shift_store_core.sv =====
// positional list store: an ordered list of up to MAX_ENTRIES values kept in a
// row of cells, position 0 at the bottom.
// channels: req carries operation, position and value; rsp carries status,
// entry_out, entry_count, is_full and is_empty, exactly one item per request.
// each request is carried out at the accepting edge: every cell shifts up,
// shifts down, loads or holds on its own compare with the position, and the
// result lands in the output register, valid on the next cycle.
// throughput is one item per cycle unless the receiver stalls; req.ready is high while the output
// register is empty or being taken in the same cycle.
// when the receiver stalls, the result is held and req.ready drops until it
// is taken, so no item is lost.
// reset clears the entry count and the output valid; cell contents are left
// as they are, since cells at or above the count are never read.
// a failed request (bad position, insert into a full list, unknown operation)
// changes nothing and returns status 1 with entry_out zero.

`default_nettype none

module positional_list_shift_store_core #(
    parameter int MAX_ENTRIES = plss_pkg::MAX_ENTRIES_DEF,
    parameter int ENTRY_WIDTH = plss_pkg::ENTRY_WIDTH_DEF
) (
    input wire logic  clk,
    input wire logic  rst_n,
    plss_req_if.sink  req,
    plss_rsp_if.source rsp
);

    localparam int LW   = $clog2(MAX_ENTRIES + 1);
    localparam int CMPW = (LW > plss_pkg::POS_WIDTH) ? LW : plss_pkg::POS_WIDTH;

    logic                   accept;
    logic [LW-1:0]          length_reg;
    logic [LW-1:0]          length_next;
    logic [CMPW-1:0]        pos_ext;
    logic [CMPW-1:0]        len_ext;
    logic                   full_now;
    logic                   ins_ok;
    logic                   rem_ok;
    logic                   ret_ok;
    logic                   rep_ok;
    logic                   clr_ok;
    logic                   fail;
    logic [ENTRY_WIDTH-1:0] wr_value;
    logic [ENTRY_WIDTH-1:0] rd_any;
    logic [ENTRY_WIDTH-1:0] got;
    plss_pkg::cell_cmd_t    cmd;
    plss_pkg::rsp_t         rsp_reg;
    plss_pkg::rsp_t         rsp_next;
    logic                   out_valid_reg;

    logic [ENTRY_WIDTH-1:0] cell_data [MAX_ENTRIES];
    logic [ENTRY_WIDTH-1:0] cell_rd   [MAX_ENTRIES];

    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign pos_ext  = CMPW'(req.data.position);
    assign len_ext  = CMPW'(length_reg);
    assign full_now = (length_reg == LW'(MAX_ENTRIES));

    assign ins_ok = (req.data.operation == plss_pkg::OP_INSERT) && !full_now
                    && (pos_ext <= len_ext);
    assign rem_ok = (req.data.operation == plss_pkg::OP_REMOVE) && (pos_ext < len_ext);
    assign ret_ok = (req.data.operation == plss_pkg::OP_RETRIEVE) && (pos_ext < len_ext);
    assign rep_ok = (req.data.operation == plss_pkg::OP_REPLACE) && (pos_ext < len_ext);
    assign clr_ok = (req.data.operation == plss_pkg::OP_CLEAR);
    assign fail   = !(ins_ok || rem_ok || ret_ok || rep_ok || clr_ok);

    assign wr_value = ENTRY_WIDTH'(req.data.value);

    assign cmd.ins = accept && ins_ok;
    assign cmd.rem = accept && rem_ok;
    assign cmd.rep = accept && rep_ok;
    assign cmd.pos = req.data.position;

    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        logic [ENTRY_WIDTH-1:0] lower;
        logic [ENTRY_WIDTH-1:0] upper;

        if (i == 0)
        begin : g_bottom
            assign lower = '0;
        end
        else
        begin : g_lower
            assign lower = cell_data[i-1];
        end

        if (i == MAX_ENTRIES - 1)
        begin : g_top
            assign upper = cell_data[i];
        end
        else
        begin : g_upper
            assign upper = cell_data[i+1];
        end

        plss_cell #(
            .MAX_ENTRIES (MAX_ENTRIES),
            .ENTRY_WIDTH (ENTRY_WIDTH),
            .INDEX       (i)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .wr_data    (wr_value),
            .lower_data (lower),
            .upper_data (upper),
            .data       (cell_data[i]),
            .rd_data    (cell_rd[i])
        );
    end

    // at most one cell hits, so an or across the row selects it
    always_comb
    begin
        rd_any = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            rd_any = rd_any | cell_rd[i];
        end
    end

    assign got = (rem_ok || ret_ok) ? rd_any : '0;

    always_comb
    begin
        length_next = length_reg;
        if (ins_ok)
        begin
            length_next = length_reg + LW'(1);
        end
        else if (rem_ok)
        begin
            length_next = length_reg - LW'(1);
        end
        else if (clr_ok)
        begin
            length_next = '0;
        end
    end

    always_comb
    begin
        rsp_next.status      = fail;
        rsp_next.entry_out   = plss_pkg::VALUE_WIDTH'(got);
        rsp_next.entry_count = plss_pkg::COUNT_WIDTH'(length_next);
        rsp_next.is_full     = (length_next == LW'(MAX_ENTRIES));
        rsp_next.is_empty    = (length_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                length_reg    <= length_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = rsp_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/plss_cell.sv =====
`default_nettype none

module plss_cell #(
    parameter int MAX_ENTRIES = plss_pkg::MAX_ENTRIES_DEF,
    parameter int ENTRY_WIDTH = plss_pkg::ENTRY_WIDTH_DEF,
    parameter int INDEX       = 0
) (
    input  wire logic                   clk,
    input  wire plss_pkg::cell_cmd_t    cmd,
    input  wire logic [ENTRY_WIDTH-1:0] wr_data,
    input  wire logic [ENTRY_WIDTH-1:0] lower_data,
    input  wire logic [ENTRY_WIDTH-1:0] upper_data,
    output logic      [ENTRY_WIDTH-1:0] data,
    output logic      [ENTRY_WIDTH-1:0] rd_data
);

    localparam int IW   = $clog2(MAX_ENTRIES);
    localparam int CMPW = (IW > plss_pkg::POS_WIDTH) ? IW : plss_pkg::POS_WIDTH;

    logic [CMPW-1:0]        idx;
    logic [CMPW-1:0]        pos_ext;
    logic                   hit;
    logic                   above;
    logic [ENTRY_WIDTH-1:0] data_reg;
    logic [ENTRY_WIDTH-1:0] data_next;

    assign idx     = CMPW'(INDEX);
    assign pos_ext = CMPW'(cmd.pos);
    assign hit     = (idx == pos_ext);
    assign above   = (idx > pos_ext);

    always_comb
    begin
        data_next = data_reg;
        if (cmd.ins && hit)
        begin
            data_next = wr_data;
        end
        else if (cmd.ins && above)
        begin
            // make room: take the entry from one place below
            data_next = lower_data;
        end
        else if (cmd.rem && (hit || above))
        begin
            // close the gap: take the entry from one place above
            data_next = upper_data;
        end
        else if (cmd.rep && hit)
        begin
            data_next = wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    assign rd_data = hit ? data_reg : '0;

endmodule

`default_nettype wire
